// ===== hdl/pwsg_pkg.sv =====
// shared types, widths and the quarter-wave sine table of the waveform sample generator
// no dependencies
`timescale 1ns / 1ps

package pwsg_pkg;

  localparam int IDX_W = 15;          // sample index
  localparam int CNT_W = 16;          // sample count register
  localparam int N_W   = CNT_W + 1;   // clamped sample count
  localparam int P_W   = 12;          // peak-to-peak register
  localparam int MV_W  = 12;          // output sample
  localparam int SH_W  = 3;           // shape register
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = CNT_W;
  localparam int T_W   = N_W + 2;     // signed 2x - b
  localparam int NUM_W = IDX_W + 16;  // dividend magnitude
  localparam int DEN_W = N_W + 1;     // divisor, up to twice the clamped count
  localparam int Q_W   = 16;          // quotient bits, one per divider stage
  localparam int VAL_W = 18;          // pre-saturation sample

  localparam int DEF_MAX_SAMPLES = 32768;
  localparam int DEF_MAX_P2P_MV  = 3000;

  typedef enum logic [SH_W-1:0] {
    SHAPE_DC       = 3'd0,
    SHAPE_SINE     = 3'd1,
    SHAPE_SQUARE   = 3'd2,
    SHAPE_TRIANGLE = 3'd3,
    SHAPE_SAWTOOTH = 3'd4
  } pwsg_shape_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHAPE = 2'd0,
    CFG_COUNT = 2'd1,
    CFG_P2P   = 2'd2
  } pwsg_cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_DIRECT,
    KIND_DIV,
    KIND_SINE
  } pwsg_kind_e;

  typedef struct packed {
    logic [SH_W-1:0] shape;
    logic [N_W-1:0]  n;
    logic [P_W-1:0]  p;
  } pwsg_cfg_t;

  typedef struct packed {
    pwsg_kind_e              kind;
    logic                    neg;
    logic                    err;
    logic signed [MV_W-1:0]  direct;
    logic [P_W-1:0]          p;
  } pwsg_side_t;

  function automatic logic [15:0] sine_quarter(input logic [5:0] k);
    logic [15:0] v;
    unique case (k)
      6'd0:  v = 16'd0;     6'd1:  v = 16'd1608;  6'd2:  v = 16'd3212;
      6'd3:  v = 16'd4808;  6'd4:  v = 16'd6393;  6'd5:  v = 16'd7962;
      6'd6:  v = 16'd9512;  6'd7:  v = 16'd11039; 6'd8:  v = 16'd12539;
      6'd9:  v = 16'd14010; 6'd10: v = 16'd15446; 6'd11: v = 16'd16846;
      6'd12: v = 16'd18204; 6'd13: v = 16'd19519; 6'd14: v = 16'd20787;
      6'd15: v = 16'd22005; 6'd16: v = 16'd23170; 6'd17: v = 16'd24279;
      6'd18: v = 16'd25329; 6'd19: v = 16'd26319; 6'd20: v = 16'd27245;
      6'd21: v = 16'd28105; 6'd22: v = 16'd28898; 6'd23: v = 16'd29621;
      6'd24: v = 16'd30273; 6'd25: v = 16'd30852; 6'd26: v = 16'd31356;
      6'd27: v = 16'd31785; 6'd28: v = 16'd32137; 6'd29: v = 16'd32412;
      6'd30: v = 16'd32609; 6'd31: v = 16'd32728;
      default: v = 16'd32767;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/pwsg_prep.sv =====
// front stages: range check, shape decode and numerator/denominator forming
// depends on pwsg_pkg
`timescale 1ns / 1ps

module pwsg_prep (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [pwsg_pkg::IDX_W-1:0]    sample_index_i,
  input  pwsg_pkg::pwsg_cfg_t           cfg_i,
  output logic                          valid_o,
  output logic [pwsg_pkg::NUM_W-1:0]    num_o,
  output logic [pwsg_pkg::DEN_W-1:0]    den_o,
  output pwsg_pkg::pwsg_side_t          side_o
);
  import pwsg_pkg::*;

  // stage 1: captured index
  logic             v1_q;
  logic [IDX_W-1:0] idx1_q;

  logic [N_W-1:0] i17, half, up, x, b;
  logic [DEN_W-1:0] den1;
  logic signed [T_W-1:0] t1;
  pwsg_side_t side1;

  always_comb begin
    i17  = N_W'(idx1_q);
    half = cfg_i.n >> 1;
    up   = cfg_i.n - half;
    x    = i17;
    b    = cfg_i.n;
    den1 = DEN_W'(1);
    side1.kind   = KIND_ZERO;
    side1.neg    = 1'b0;
    side1.err    = (i17 >= cfg_i.n);
    side1.direct = '0;
    side1.p      = cfg_i.p;
    unique case (cfg_i.shape)
      SHAPE_SINE: begin
        side1.kind = KIND_SINE;
        den1 = cfg_i.n;
      end
      SHAPE_SQUARE: begin
        side1.kind   = KIND_DIRECT;
        side1.direct = (i17 < half) ? -$signed(MV_W'(cfg_i.p >> 1))
                                    : $signed(MV_W'(cfg_i.p >> 1));
      end
      SHAPE_TRIANGLE: begin
        side1.kind = KIND_DIV;
        if (i17 < up) begin
          x = i17;
          b = up;
        end else begin
          x = cfg_i.n - i17;
          b = half;
        end
        den1 = DEN_W'({b, 1'b0});
      end
      SHAPE_SAWTOOTH: begin
        side1.kind = KIND_DIV;
        den1 = DEN_W'({b, 1'b0});
      end
      default: side1.kind = KIND_ZERO;
    endcase
    if (side1.err) begin
      side1.kind = KIND_ZERO;
      den1 = DEN_W'(1);
    end
    t1 = $signed({1'b0, x, 1'b0}) - $signed({2'b00, b});
  end

  // stage 2: operands ready for the multiply
  logic                  v2_q;
  logic [IDX_W-1:0]      idx2_q;
  logic signed [T_W-1:0] t2_q;
  logic [DEN_W-1:0]      den2_q;
  pwsg_side_t            side2_q;

  logic signed [31:0] prod2, mag2;
  logic               neg2;
  pwsg_side_t         side2;
  logic [NUM_W-1:0]   num2;

  always_comb begin
    prod2 = $signed({1'b0, side2_q.p}) * t2_q;
    neg2  = prod2 < 0;
    mag2  = neg2 ? -prod2 : prod2;
    side2 = side2_q;
    side2.neg = neg2 && (side2_q.kind == KIND_DIV);
    num2  = (side2_q.kind == KIND_SINE) ? {idx2_q, 16'd0} : mag2[NUM_W-1:0];
  end

  logic v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      idx1_q  <= sample_index_i;
      idx2_q  <= idx1_q;
      t2_q    <= t1;
      den2_q  <= den1;
      side2_q <= side1;
      num_o   <= num2;
      den_o   <= den2_q;
      side_o  <= side2;
    end
  end

  assign valid_o = v3_q;

endmodule

// ===== hdl/pwsg_div.sv =====
// pipelined restoring divider, one quotient bit per stage, side data carried along
// depends on pwsg_pkg
`timescale 1ns / 1ps

module pwsg_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [pwsg_pkg::NUM_W-1:0]    num_i,
  input  logic [pwsg_pkg::DEN_W-1:0]    den_i,
  input  pwsg_pkg::pwsg_side_t          side_i,
  output logic                          valid_o,
  output logic [pwsg_pkg::Q_W-1:0]      quot_o,
  output pwsg_pkg::pwsg_side_t          side_o
);
  import pwsg_pkg::*;

  logic             v_q   [Q_W];
  logic [DEN_W-1:0] r_q   [Q_W];
  logic [Q_W-1:0]   q_q   [Q_W];
  logic [NUM_W-1:0] dv_q  [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];
  pwsg_side_t       side_q[Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic             v_prev;
    logic [DEN_W-1:0] r_prev, den_prev, r_new;
    logic [Q_W-1:0]   q_prev;
    logic [NUM_W-1:0] dv_prev;
    pwsg_side_t       side_prev;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (k == 0) begin : g_first
      // the quotient fits in Q_W bits, so the upper dividend bits stay below the divisor
      assign v_prev    = valid_i;
      assign r_prev    = DEN_W'(num_i[NUM_W-1:Q_W]);
      assign q_prev    = '0;
      assign dv_prev   = num_i;
      assign den_prev  = den_i;
      assign side_prev = side_i;
    end else begin : g_next
      assign v_prev    = v_q[k-1];
      assign r_prev    = r_q[k-1];
      assign q_prev    = q_q[k-1];
      assign dv_prev   = dv_q[k-1];
      assign den_prev  = den_q[k-1];
      assign side_prev = side_q[k-1];
    end

    always_comb begin
      trial = {r_prev, dv_prev[Q_W-1-k]};
      ge    = trial >= {1'b0, den_prev};
      r_new = ge ? DEN_W'(trial - {1'b0, den_prev}) : DEN_W'(trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_prev;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k]    <= r_new;
        q_q[k]    <= {q_prev[Q_W-2:0], ge};
        dv_q[k]   <= dv_prev;
        den_q[k]  <= den_prev;
        side_q[k] <= side_prev;
      end
    end
  end

  assign valid_o = v_q[Q_W-1];
  assign quot_o  = q_q[Q_W-1];
  assign side_o  = side_q[Q_W-1];

endmodule

// ===== hdl/pwsg_post.sv =====
// back stages: sine interpolation and scaling, sign, selection, saturation, output register
// depends on pwsg_pkg
`timescale 1ns / 1ps

module pwsg_post (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [pwsg_pkg::Q_W-1:0]          quot_i,
  input  pwsg_pkg::pwsg_side_t              side_i,
  output logic                              valid_o,
  output logic signed [pwsg_pkg::MV_W-1:0]  sample_mv_o,
  output logic                              index_error_o
);
  import pwsg_pkg::*;

  // stage a: quadrant fold and table read
  logic [1:0]  quad;
  logic [14:0] um;
  logic [15:0] base_a, diff_a;
  logic [8:0]  f_a;
  logic signed [16:0] dv_a;

  always_comb begin
    quad = quot_i[15:14];
    um   = quad[0] ? 15'd16384 - {1'b0, quot_i[13:0]} : {1'b0, quot_i[13:0]};
    if (um[14]) begin
      base_a = sine_quarter(6'd32);
      diff_a = '0;
      f_a    = '0;
    end else begin
      base_a = sine_quarter({1'b0, um[13:9]});
      diff_a = sine_quarter({1'b0, um[13:9]} + 6'd1) - base_a;
      f_a    = um[8:0];
    end
    dv_a = side_i.neg ? -$signed({1'b0, quot_i}) : $signed({1'b0, quot_i});
  end

  logic               va_q, vb_q, vc_q, vo_q;
  logic [15:0]        base_q, diff_q;
  logic [8:0]         f_q;
  logic               sneg_q;
  logic signed [16:0] dva_q, dvb_q, dvc_q;
  pwsg_side_t         sa_q, sb_q, sc_q;

  // stage b: interpolate
  logic [24:0]        fprod;
  logic [15:0]        smag;
  logic signed [16:0] s_b, s_q;

  always_comb begin
    fprod = diff_q * f_q;
    smag  = base_q + 16'(fprod >> 9);
    s_b   = sneg_q ? -$signed({1'b0, smag}) : $signed({1'b0, smag});
  end

  // stage c: scale by amplitude
  logic signed [30:0] pc_q;
  logic signed [30:0] p_c;

  assign p_c = $signed({1'b0, sb_q.p}) * s_q;

  // stage d: truncate toward zero, select, saturate
  logic signed [30:0]      pmag;
  logic [14:0]             psh;
  logic signed [VAL_W-1:0] sv, val;
  logic signed [MV_W-1:0]  mv_d;

  always_comb begin
    pmag = (pc_q < 0) ? -pc_q : pc_q;
    psh  = 15'(pmag >>> 16);
    sv   = (pc_q < 0) ? -$signed({3'b000, psh}) : $signed({3'b000, psh});
    unique case (sc_q.kind)
      KIND_ZERO:   val = '0;
      KIND_DIRECT: val = VAL_W'(sc_q.direct);
      KIND_DIV:    val = VAL_W'(dvc_q);
      KIND_SINE:   val = sv;
      default:     val = '0;
    endcase
    if (sc_q.err) val = '0;
    if (val > $signed(VAL_W'(2047)))       mv_d = 12'sd2047;
    else if (val < -$signed(VAL_W'(2048))) mv_d = -12'sd2048;
    else                                   mv_d = MV_W'(val);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vo_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      base_q <= base_a;
      diff_q <= diff_a;
      f_q    <= f_a;
      sneg_q <= quad[1];
      dva_q  <= dv_a;
      sa_q   <= side_i;
      s_q    <= s_b;
      dvb_q  <= dva_q;
      sb_q   <= sa_q;
      pc_q   <= p_c;
      dvc_q  <= dvb_q;
      sc_q   <= sb_q;
      sample_mv_o   <= mv_d;
      index_error_o <= sc_q.err;
    end
  end

  assign valid_o = vo_q;

endmodule

// ===== hdl/periodic_waveform_sample_generator_top.sv =====
// top level of the waveform sample generator: config registers, clamp and the pipeline
// depends on pwsg_pkg, pwsg_prep, pwsg_div, pwsg_post
//
//  channel | direction | handshake                 | payload
//  in      | input     | in_valid_i / in_stall_o   | sample_index_i
//  out     | output    | out_valid_o / out_stall_i | sample_mv_o, index_error_o
//  cfg     | input     | cfg_we_i                  | cfg_idx_i, cfg_data_i
//
// one sample per clock sustained while the result is not stalled; the pipeline holds
// three front stages, sixteen divider stages of one quotient bit each, four back stages
// reset clears valid bits and restores shape dc, count 1, amplitude 0
// a stalled result freezes the whole pipeline, so in_stall_o follows a stalled output
`timescale 1ns / 1ps

module periodic_waveform_sample_generator_top #(
  parameter int MAX_SAMPLES = pwsg_pkg::DEF_MAX_SAMPLES,
  parameter int MAX_P2P_MV  = pwsg_pkg::DEF_MAX_P2P_MV
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [pwsg_pkg::IDX_W-1:0]        sample_index_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [pwsg_pkg::MV_W-1:0]  sample_mv_o,
  output logic                              index_error_o,
  input  logic                              cfg_we_i,
  input  logic [pwsg_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pwsg_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import pwsg_pkg::*;

  logic [SH_W-1:0]  shape_q;
  logic [CNT_W-1:0] count_q;
  logic [P_W-1:0]   p2p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q <= SHAPE_DC;
      count_q <= CNT_W'(1);
      p2p_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SHAPE: shape_q <= cfg_data_i[SH_W-1:0];
        CFG_COUNT: count_q <= cfg_data_i;
        CFG_P2P:   p2p_q   <= cfg_data_i[P_W-1:0];
        default: ;
      endcase
    end
  end

  pwsg_cfg_t cfg;

  always_comb begin
    cfg.shape = shape_q;
    cfg.n = (32'(count_q) > MAX_SAMPLES) ? N_W'(MAX_SAMPLES) : N_W'(count_q);
    cfg.p = (32'(p2p_q) > MAX_P2P_MV) ? P_W'(MAX_P2P_MV) : p2p_q;
  end

  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  logic             pv, dv;
  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] den;
  logic [Q_W-1:0]   quot;
  pwsg_side_t       pside, dside;

  pwsg_prep u_prep (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(in_valid_i), .sample_index_i, .cfg_i(cfg),
    .valid_o(pv), .num_o(num), .den_o(den), .side_o(pside)
  );

  pwsg_div u_div (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(pv), .num_i(num), .den_i(den), .side_i(pside),
    .valid_o(dv), .quot_o(quot), .side_o(dside)
  );

  pwsg_post u_post (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(dv), .quot_i(quot), .side_i(dside),
    .valid_o(out_valid_o), .sample_mv_o, .index_error_o
  );

endmodule

// ===== hdl/pwsg_checker.sv =====
// port-level checks of the waveform sample generator, bound to the top level
// depends on nothing but the top level's ports
`timescale 1ns / 1ps

module pwsg_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic signed [11:0] sample_mv_o,
  input logic              index_error_o
);

  // a stalled result beat stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped under stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(sample_mv_o) && $stable(index_error_o))
    else $error("stalled result beat changed");

  // out of range index gives a zero sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && index_error_o |-> sample_mv_o == 12'sd0)
    else $error("index error with nonzero sample");

  // input is held back only by a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o == (out_valid_o && out_stall_i))
    else $error("input stall without output back-pressure");

endmodule

bind periodic_waveform_sample_generator_top pwsg_checker u_pwsg_checker (
  .clk_i, .rst_ni, .in_stall_o, .out_valid_o, .out_stall_i,
  .sample_mv_o, .index_error_o
);
